// ===== sv/mlm_pkg.sv =====
package mlm_pkg;

  localparam int unsigned TEXT_BYTES = 8;
  localparam int unsigned SLOT_MAX   = 3;
  localparam int unsigned KW_COUNT   = 4;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;

  // Keyword bit positions in the per-line keyword flags.
  localparam int unsigned KW_ERROR = 0;
  localparam int unsigned KW_WARN  = 1;
  localparam int unsigned KW_INFO  = 2;
  localparam int unsigned KW_DEBUG = 3;

  typedef enum logic [2:0] {
    REG_PAT_A_TEXT = 3'd0,
    REG_PAT_A_LEN  = 3'd1,
    REG_PAT_B_TEXT = 3'd2,
    REG_PAT_B_LEN  = 3'd3,
    REG_PAT_C_TEXT = 3'd4,
    REG_PAT_C_LEN  = 3'd5,
    REG_FOLD_CASE  = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    LVL_NONE  = 3'd0,
    LVL_DEBUG = 3'd1,
    LVL_INFO  = 3'd2,
    LVL_WARN  = 3'd3,
    LVL_ERROR = 3'd4
  } level_e;

  typedef struct packed {
    logic [8*TEXT_BYTES-1:0] text;
    logic [3:0]              len;
  } pat_cfg_t;

  typedef struct packed {
    logic [SLOT_MAX-1:0] slot_ok;
    logic [KW_COUNT-1:0] kw_ok;
  } cell_ok_t;

  // Keywords stored like patterns: first character in the lowest byte.
  // "warning" needs no entry of its own since it always contains "warn".
  localparam pat_cfg_t KW_CFG [KW_COUNT] = '{
    '{text: 64'h0000_0072_6f72_7265, len: 4'd5},  // error
    '{text: 64'h0000_0000_6e72_6177, len: 4'd4},  // warn
    '{text: 64'h0000_0000_6f66_6e69, len: 4'd4},  // info
    '{text: 64'h0000_0067_7562_6564, len: 4'd5}   // debug
  };

  // A history byte at depth idx (0 = newest before the current byte) must equal
  // the sequence byte len-2-idx; depths beyond the sequence impose nothing.
  function automatic logic tail_ok(logic [8*TEXT_BYTES-1:0] text, logic [3:0] len,
                                   int unsigned idx, logic valid, logic [7:0] hist);
    logic [3:0] pos;
    logic       ok;
    pos = '0;
    ok  = 1'b1;
    if (32'(len) >= idx + 32'd2) begin
      pos = 4'(32'(len) - idx - 32'd2);
      ok  = valid && (hist == text[8*pos[2:0] +: 8]);
    end
    return ok;
  endfunction

  // The current byte must equal the last byte of the sequence.
  function automatic logic head_ok(logic [8*TEXT_BYTES-1:0] text, logic [3:0] len,
                                   logic [7:0] cur);
    logic [3:0] last;
    last = len - 4'd1;
    return (len != 4'd0) && (cur == text[8*last[2:0] +: 8]);
  endfunction

endpackage

// ===== sv/mlm_cfg_regs.sv =====
module mlm_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mlm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mlm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mlm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output mlm_pkg::pat_cfg_t               pat_o [mlm_pkg::SLOT_MAX],
  output logic                            fold_o
);
  import mlm_pkg::*;

  pat_cfg_t pat_q [SLOT_MAX];
  logic     fold_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOT_MAX; s++) begin
        pat_q[s] <= '0;
      end
      fold_q <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_PAT_A_TEXT: pat_q[0].text <= pwdata;
        REG_PAT_A_LEN:  pat_q[0].len  <= pwdata[3:0];
        REG_PAT_B_TEXT: pat_q[1].text <= pwdata;
        REG_PAT_B_LEN:  pat_q[1].len  <= pwdata[3:0];
        REG_PAT_C_TEXT: pat_q[2].text <= pwdata;
        REG_PAT_C_LEN:  pat_q[2].len  <= pwdata[3:0];
        REG_FOLD_CASE:  fold_q        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAT_A_TEXT: prdata = pat_q[0].text;
      REG_PAT_A_LEN:  prdata = {{(CFG_DATA_W-4){1'b0}}, pat_q[0].len};
      REG_PAT_B_TEXT: prdata = pat_q[1].text;
      REG_PAT_B_LEN:  prdata = {{(CFG_DATA_W-4){1'b0}}, pat_q[1].len};
      REG_PAT_C_TEXT: prdata = pat_q[2].text;
      REG_PAT_C_LEN:  prdata = {{(CFG_DATA_W-4){1'b0}}, pat_q[2].len};
      REG_FOLD_CASE:  prdata = {{(CFG_DATA_W-1){1'b0}}, fold_q};
      default:        prdata = '0;
    endcase
  end

  assign pat_o  = pat_q;
  assign fold_o = fold_q;

endmodule

// ===== sv/mlm_cell.sv =====
module mlm_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic              clear_i,
  input  logic [7:0]        byte_i,
  input  logic              valid_i,
  input  mlm_pkg::pat_cfg_t pat_i [mlm_pkg::SLOT_MAX],
  output logic [7:0]        byte_o,
  output logic              valid_o,
  output mlm_pkg::cell_ok_t ok_o
);
  import mlm_pkg::*;

  logic [7:0] byte_q;
  logic       valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // Each cell checks its own history byte against every pattern and keyword.
  always_comb begin
    for (int s = 0; s < SLOT_MAX; s++) begin
      ok_o.slot_ok[s] = tail_ok(pat_i[s].text, pat_i[s].len, CellIdx, valid_q, byte_q);
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      ok_o.kw_ok[k] = tail_ok(KW_CFG[k].text, KW_CFG[k].len, CellIdx, valid_q, byte_q);
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// ===== sv/multi_pattern_line_matcher.sv =====
// A line-end request is answered in the cycle after it is accepted.
// Throughput: one request per cycle; bytes are taken even while a result waits,
// and a line end is held off only while the previous result is still stalled.
// Line bytes move through a row of history cells, one cell per accepted byte.
// Reset clears configuration, line state and the matched-line count.
module multi_pattern_line_matcher #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned PATTERN_SLOTS     = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     char_byte_i,
  input  logic                           closes_line_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           line_matched_o,
  output logic [2:0]                     log_level_o,
  output logic [31:0]                    matched_lines_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mlm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mlm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mlm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mlm_pkg::*;

  localparam int unsigned HistLen = ((MAX_PATTERN_BYTES > 7) ? MAX_PATTERN_BYTES : 7) - 1;
  localparam int unsigned PatCap  = (MAX_PATTERN_BYTES < TEXT_BYTES) ?
                                    MAX_PATTERN_BYTES : TEXT_BYTES;

  pat_cfg_t pat_raw [SLOT_MAX];
  pat_cfg_t pat_eff [SLOT_MAX];
  logic     fold;

  logic       in_acc, byte_acc, line_end;
  logic [7:0] cur_byte;

  logic [7:0] cell_byte  [HistLen];
  logic       cell_valid [HistLen];
  cell_ok_t   cell_ok    [HistLen];

  logic [SLOT_MAX-1:0] slot_hit;
  logic [KW_COUNT-1:0] kw_hit;

  logic [PATTERN_SLOTS-1:0] pat_seen_q, pat_seen_d;
  logic [KW_COUNT-1:0]      kw_seen_q, kw_seen_d;
  logic [31:0]              total_q, total_d;
  logic                     out_valid_q, out_valid_d;
  logic                     matched_q, matched_d;
  level_e                   level_q, level_d;

  mlm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pat_o   (pat_raw),
    .fold_o  (fold)
  );

  // Lengths beyond what a pattern can hold are clipped.
  always_comb begin
    for (int s = 0; s < SLOT_MAX; s++) begin
      pat_eff[s].text = pat_raw[s].text;
      pat_eff[s].len  = (32'(pat_raw[s].len) > PatCap) ? 4'(PatCap) : pat_raw[s].len;
    end
  end

  // A line end must wait only when the previous result is still held.
  assign in_stall_o = out_valid_q && out_stall_i && closes_line_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign byte_acc   = in_acc && !closes_line_i;
  assign line_end   = in_acc && closes_line_i;

  always_comb begin
    cur_byte = char_byte_i;
    if (fold && (char_byte_i inside {[8'h41:8'h5a]})) begin
      cur_byte = char_byte_i + 8'h20;
    end
  end

  for (genvar k = 0; k < HistLen; k++) begin : g_cell
    logic [7:0] byte_in;
    logic       valid_in;
    if (k == 0) begin : g_head
      assign byte_in  = cur_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = cell_byte[k-1];
      assign valid_in = cell_valid[k-1];
    end
    mlm_cell #(.CellIdx(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (byte_acc),
      .clear_i (line_end),
      .byte_i  (byte_in),
      .valid_i (valid_in),
      .pat_i   (pat_eff),
      .byte_o  (cell_byte[k]),
      .valid_o (cell_valid[k]),
      .ok_o    (cell_ok[k])
    );
  end

  always_comb begin
    for (int s = 0; s < SLOT_MAX; s++) begin
      slot_hit[s] = head_ok(pat_eff[s].text, pat_eff[s].len, cur_byte);
    end
    for (int w = 0; w < KW_COUNT; w++) begin
      kw_hit[w] = head_ok(KW_CFG[w].text, KW_CFG[w].len, cur_byte);
    end
    for (int k = 0; k < HistLen; k++) begin
      slot_hit = slot_hit & cell_ok[k].slot_ok;
      kw_hit   = kw_hit & cell_ok[k].kw_ok;
    end
  end

  always_comb begin
    pat_seen_d  = pat_seen_q;
    kw_seen_d   = kw_seen_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    matched_d   = matched_q;
    level_d     = level_q;
    if (byte_acc) begin
      pat_seen_d = pat_seen_q | slot_hit[PATTERN_SLOTS-1:0];
      kw_seen_d  = kw_seen_q | kw_hit;
    end else if (line_end) begin
      pat_seen_d  = '0;
      kw_seen_d   = '0;
      out_valid_d = 1'b1;
      matched_d   = |pat_seen_q;
      level_d     = LVL_NONE;
      if (|pat_seen_q) begin
        if (total_q != '1) begin
          total_d = total_q + 32'd1;
        end
        if (kw_seen_q[KW_ERROR]) begin
          level_d = LVL_ERROR;
        end else if (kw_seen_q[KW_WARN]) begin
          level_d = LVL_WARN;
        end else if (kw_seen_q[KW_INFO]) begin
          level_d = LVL_INFO;
        end else if (kw_seen_q[KW_DEBUG]) begin
          level_d = LVL_DEBUG;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_seen_q  <= '0;
      kw_seen_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pat_seen_q  <= pat_seen_d;
      kw_seen_q   <= kw_seen_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    level_q   <= level_d;
  end

  // The count changes only together with a new result, so it drives the port.
  assign out_valid_o     = out_valid_q;
  assign line_matched_o  = matched_q;
  assign log_level_o     = level_q;
  assign matched_lines_o = total_q;

  a_line_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_end |=> out_valid_q)
    else $error("line end did not produce a result");

  a_held_result_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(total_q))
    else $error("count changed while a result was held");

  a_level_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (matched_q || level_q == LVL_NONE))
    else $error("level reported for an unmatched line");

  a_line_end_clears_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_end |=> (!cell_valid[0] && pat_seen_q == '0 && kw_seen_q == '0))
    else $error("line state not cleared at line end");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import mlm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 230;
  localparam int unsigned PRINT_CAP   = 200;

  typedef struct {
    bit        matched;
    level_e    level;
    bit [31:0] count;
  } verdict_t;

  // Tracks the line state and configuration of the matcher and holds the verdicts
  // that accepted line ends are still owed.
  class line_filter_tracker;
    localparam int unsigned HIST_DEPTH = 7;
    localparam int unsigned PAT_CAP    = 8;

    bit [63:0]         pat_text [SLOT_MAX];
    bit [3:0]          pat_len  [SLOT_MAX];
    bit                fold;
    bit [7:0]          history  [HIST_DEPTH];
    int unsigned       held;
    bit [SLOT_MAX-1:0] slot_hit;
    bit [KW_COUNT-1:0] kw_hit;
    bit [31:0]         total;
    verdict_t          pending_verdicts [$];
    int unsigned       errors;

    static function bit [63:0] pack(string s);
      bit [63:0] t;
      t = '0;
      for (int i = 0; i < s.len() && i < 8; i++) t[8*i +: 8] = s[i];
      return t;
    endfunction

    function void set_register(reg_idx_e idx, bit [63:0] value);
      case (idx)
        REG_PAT_A_TEXT: pat_text[0] = value;
        REG_PAT_A_LEN:  pat_len[0]  = value[3:0];
        REG_PAT_B_TEXT: pat_text[1] = value;
        REG_PAT_B_LEN:  pat_len[1]  = value[3:0];
        REG_PAT_C_TEXT: pat_text[2] = value;
        REG_PAT_C_LEN:  pat_len[2]  = value[3:0];
        REG_FOLD_CASE:  fold        = value[0];
        default: ;
      endcase
    endfunction

    // True if the first len bytes of text end at cur, earlier bytes in the history.
    function bit ends_with(bit [63:0] text, int unsigned len, bit [7:0] cur);
      if (len == 0 || len > HIST_DEPTH + 1 || len > held + 1) return 1'b0;
      if (text[8*(len-1) +: 8] != cur) return 1'b0;
      for (int k = 1; k < len; k++) begin
        if (text[8*(len-1-k) +: 8] != history[k-1]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit keyword_ends(string w, bit [7:0] cur);
      return ends_with(pack(w), w.len(), cur);
    endfunction

    function void take_request(bit [7:0] b, bit close);
      verdict_t    v;
      bit [7:0]    c;
      int unsigned len;
      if (close) begin
        v.matched = (slot_hit != '0);
        v.level   = LVL_NONE;
        if (v.matched) begin
          if (total != 32'hFFFF_FFFF) total++;
          if (kw_hit[KW_ERROR])      v.level = LVL_ERROR;
          else if (kw_hit[KW_WARN])  v.level = LVL_WARN;
          else if (kw_hit[KW_INFO])  v.level = LVL_INFO;
          else if (kw_hit[KW_DEBUG]) v.level = LVL_DEBUG;
        end
        v.count = total;
        pending_verdicts = {pending_verdicts, v};
        history  = '{default: 8'h00};
        held     = 0;
        slot_hit = '0;
        kw_hit   = '0;
        return;
      end
      c = b;
      // ASCII A..Z fold to a..z.
      if (fold && c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
      for (int s = 0; s < SLOT_MAX; s++) begin
        len = (pat_len[s] > PAT_CAP) ? PAT_CAP : pat_len[s];
        if (ends_with(pat_text[s], len, c)) slot_hit[s] = 1'b1;
      end
      // "warning" always contains "warn", so it needs no check of its own.
      if (keyword_ends("error", c)) kw_hit[KW_ERROR] = 1'b1;
      if (keyword_ends("warn", c))  kw_hit[KW_WARN]  = 1'b1;
      if (keyword_ends("info", c))  kw_hit[KW_INFO]  = 1'b1;
      if (keyword_ends("debug", c)) kw_hit[KW_DEBUG] = 1'b1;
      for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = c;
      if (held < HIST_DEPTH) held++;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(logic matched, logic [2:0] level, logic [31:0] count);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result with no line end pending: matched %b level %0d count %0d",
                         matched, level, count));
        return;
      end
      v = pending_verdicts.pop_front();
      if (matched !== v.matched)
        report($sformatf("line_matched %b, expected %b", matched, v.matched));
      if (level !== v.level)
        report($sformatf("log_level %0d, expected %s", level, v.level.name()));
      if (count !== v.count)
        report($sformatf("matched_lines %0d, expected %0d", count, v.count));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            char_byte_i   = 8'h00;
  logic                  closes_line_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  line_matched_o;
  logic [2:0]            log_level_o;
  logic [31:0]           matched_lines_o;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  line_filter_tracker tracker;
  int unsigned        idle_pct      = 0;
  int unsigned        stall_pct     = 0;
  int unsigned        requests_sent = 0;
  int unsigned        quiet_cycles  = 0;

  bit [63:0] cfg_text [SLOT_MAX];
  bit [3:0]  cfg_len  [SLOT_MAX];
  bit        cfg_fold;

  string letters = "abdeginorw";
  string keywords [5] = '{"error", "warning", "warn", "info", "debug"};

  multi_pattern_line_matcher dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .char_byte_i,
    .closes_line_i,
    .out_valid_o,
    .out_stall_i,
    .line_matched_o,
    .log_level_o,
    .matched_lines_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_verdict(line_matched_o, log_level_o, matched_lines_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit [7:0] maybe_upper(bit [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(7) == 0) return c - 8'h20;
    return c;
  endfunction

  task automatic send_request(bit [7:0] b, bit close);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_byte_i   <= b;
    closes_line_i <= close;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_request(b, close);
    requests_sent++;
  endtask

  task automatic send_text(string s, bit close_it);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    if (close_it) send_request(8'hFF, 1'b1);
  endtask

  // Stop sending and wait until every line end has been answered.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [63:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_ADDR_W'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config;
    write_reg(REG_PAT_A_TEXT, cfg_text[0]);
    write_reg(REG_PAT_A_LEN,  64'(cfg_len[0]));
    write_reg(REG_PAT_B_TEXT, cfg_text[1]);
    write_reg(REG_PAT_B_LEN,  64'(cfg_len[1]));
    write_reg(REG_PAT_C_TEXT, cfg_text[2]);
    write_reg(REG_PAT_C_LEN,  64'(cfg_len[2]));
    write_reg(REG_FOLD_CASE,  64'(cfg_fold));
  endtask

  function automatic void pick_config(int unsigned phase);
    bit [63:0] t;
    for (int s = 0; s < SLOT_MAX; s++) begin
      case ($urandom_range(9))
        0:       cfg_len[s] = 4'd0;
        1:       cfg_len[s] = 4'd8;
        2:       cfg_len[s] = 4'($urandom_range(15, 9));
        default: cfg_len[s] = 4'($urandom_range(5, 1));
      endcase
      case ($urandom_range(5))
        0: t = {$urandom, $urandom};
        1: t = line_filter_tracker::pack(keywords[$urandom_range(4)]);
        default: begin
          for (int i = 0; i < 8; i++)
            t[8*i +: 8] = maybe_upper(letters[$urandom_range(letters.len() - 1)]);
        end
      endcase
      cfg_text[s] = t;
    end
    cfg_fold = 1'($urandom_range(1));
    if (phase == 0) begin
      cfg_text[0] = '1;
      cfg_len[0]  = 4'd8;
      cfg_text[1] = '0;
      cfg_len[1]  = 4'd15;
      cfg_len[2]  = 4'd0;
    end
  endfunction

  // A line built from pattern copies, keywords, letters and raw bytes, mostly closed.
  task automatic send_random_line;
    int unsigned segs;
    int unsigned len;
    int unsigned s;
    string       w;
    segs = $urandom_range(4);
    for (int n = 0; n < segs; n++) begin
      case ($urandom_range(4))
        0, 1: begin
          s   = $urandom_range(SLOT_MAX - 1);
          len = (cfg_len[s] > 8) ? 8 : cfg_len[s];
          for (int i = 0; i < len; i++)
            send_request(maybe_upper(cfg_text[s][8*i +: 8]), 1'b0);
        end
        2: begin
          w = keywords[$urandom_range(4)];
          for (int i = 0; i < w.len(); i++) send_request(maybe_upper(w[i]), 1'b0);
        end
        3: begin
          repeat ($urandom_range(3, 1))
            send_request(maybe_upper(letters[$urandom_range(letters.len() - 1)]), 1'b0);
        end
        default: begin
          repeat ($urandom_range(3, 1)) send_request(8'($urandom), 1'b0);
        end
      endcase
    end
    if ($urandom_range(9) != 0) send_request(8'($urandom), 1'b1);
  endtask

  initial begin
    int unsigned target;
    tracker = new;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All patterns are disabled out of reset: a plain line and an empty line.
    send_text("x", 1'b1);
    send_request(8'h00, 1'b1);
    drain();

    cfg_text[0] = line_filter_tracker::pack("ab");
    cfg_len[0]  = 4'd2;
    cfg_text[1] = '1;
    cfg_len[1]  = 4'd15;
    cfg_text[2] = line_filter_tracker::pack("WARN");
    cfg_len[2]  = 4'd4;
    cfg_fold    = 1'b1;
    apply_config();
    // Folded line hits the short pattern and the error keyword.
    send_text("ABerror", 1'b1);
    // The overlong length counts as eight bytes of 0xFF.
    repeat (8) send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b1);
    // An upper case pattern cannot match once folding is on.
    send_text("WARN", 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 86; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      pick_config(p);
      apply_config();
      target = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) send_random_line();
      // Leave a line open so the next configuration lands in the middle of it.
      repeat ($urandom_range(3)) send_request(letters[$urandom_range(letters.len() - 1)], 1'b0);
      drain();
    end

    send_request(8'hFF, 1'b1);
    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.pending_verdicts.size() != 0)
      tracker.report("line ends still unanswered at end of run");
    if (tracker.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
